### src/pal_pkg.sv
// shared types and constants for the positional array list
// no dependencies
package pal_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int POS_W        = 9;
  localparam int VAL_W        = 32;
  localparam int OUT_CNT_W    = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2,
    CM_ROTATE = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t             mode;
    logic [POS_W-1:0]       pos;
    logic [VAL_W-1:0]       value;
  } cell_ctrl_t;

endpackage

### src/pal_cell.sv
// one storage cell of the list chain: holds one entry, takes from its neighbors
// depends on pal_pkg
module pal_cell
  import pal_pkg::*;
#(
  parameter int IDX      = 0,
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] left_i,
  input  logic [VAL_W-1:0] right_i,
  output logic [VAL_W-1:0] data_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (IW > POS_W) ? IW : POS_W;
  localparam logic [PW-1:0] IdxW = PW'(IDX);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic [PW-1:0]    pos_w;

  assign pos_w = PW'(ctrl.pos);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.mode)
      CM_INSERT: begin
        if (IdxW == pos_w) begin
          data_nxt = ctrl.value;
        end else if (IdxW > pos_w) begin
          data_nxt = left_i;
        end
      end
      CM_REMOVE: begin
        if (IdxW >= pos_w) begin
          data_nxt = right_i;
        end
      end
      CM_ROTATE: data_nxt = right_i;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

### src/positional_array_list_top.sv
// positional array list: insert, remove, clear and empty search answer next cycle;
// a non-empty search reports after a full rotation of the chain (S_SCAN, then S_DONE)
// throughput: one command per cycle when the result side keeps up, except search,
// which occupies the block for the whole rotation of the cell chain
// reset (rst_n low, synchronous) empties the list; cell contents are left as they are
// depends on pal_pkg and pal_cell
module positional_array_list_top
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [8:0] position, [40:9] value, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [1:0] status, [10:2] match_count, [19:11] length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CapW  = CW'(CAPACITY);
  localparam logic [CW-1:0] LastK = CW'(CAPACITY - 1);

  // one-hot control states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     scan_k_r, scan_k_nxt;    // entry index now sitting in cell 0
  logic [CW-1:0]     cnt_r, cnt_nxt;          // running match count
  logic [VAL_W-1:0]  key_r, key_nxt;          // value searched for
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0] out_match_r, out_match_nxt;
  logic [OUT_CNT_W-1:0] out_len_r, out_len_nxt;

  cell_ctrl_t        ctrl;
  logic [VAL_W-1:0]  cell_q [CAPACITY];

  op_t               in_op;
  logic [POS_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_val;
  logic [PW-1:0]     pos_w, used_w;
  logic              in_xfer, out_free;

  assign in_op  = op_t'(in_tuser);
  assign in_pos = in_tdata[8:0];
  assign in_val = in_tdata[40:9];
  assign pos_w  = PW'(in_pos);
  assign used_w = PW'(used_r);

  // result register may take a new value this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    scan_k_nxt     = scan_k_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_match_nxt  = out_match_r;
    out_len_nxt    = out_len_r;
    ctrl.mode      = CM_HOLD;
    ctrl.pos       = in_pos;
    ctrl.value     = in_val;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_match_nxt = '0;
          out_status_nxt = ST_OK;
          case (in_op)
            OP_INSERT: begin
              // position check goes before the full check
              if (pos_w > used_w) begin
                out_status_nxt = ST_BAD_POS;
              end else if (used_r == CapW) begin
                out_status_nxt = ST_FULL;
              end else begin
                ctrl.mode = CM_INSERT;
                used_nxt  = used_r + 1'b1;
              end
            end
            OP_REMOVE: begin
              // empty check goes before the position check
              if (used_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (pos_w >= used_w) begin
                out_status_nxt = ST_BAD_POS;
              end else begin
                ctrl.mode = CM_REMOVE;
                used_nxt  = used_r - 1'b1;
              end
            end
            OP_SEARCH: begin
              if (used_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                state_nxt  = S_SCAN;
                key_nxt    = in_val;
                scan_k_nxt = '0;
                cnt_nxt    = '0;
              end
            end
            OP_CLEAR: used_nxt = '0;
            default:  used_nxt = used_r;
          endcase
          out_len_nxt = OUT_CNT_W'(used_nxt);
          // a non-empty search reports only after the rotation
          out_valid_nxt = !((in_op == OP_SEARCH) && (used_r != '0));
        end
      end
      S_SCAN: begin
        // rotate the whole chain one place; cell 0 sees every entry in turn
        ctrl.mode = CM_ROTATE;
        if ((scan_k_r < used_r) && (cell_q[0] == key_r)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        scan_k_nxt = scan_k_r + 1'b1;
        if (scan_k_r == LastK) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // chain is back in its original order; wait for the result slot
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_match_nxt  = OUT_CNT_W'(cnt_r);
          out_len_nxt    = OUT_CNT_W'(used_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    scan_k_r     <= scan_k_nxt;
    cnt_r        <= cnt_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_match_r  <= out_match_nxt;
    out_len_r    <= out_len_nxt;
  end

  // the cell chain; the top cell wraps to cell 0 for rotation
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[0];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    pal_cell #(
      .IDX      (i),
      .CAPACITY (CAPACITY)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cell_q[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_len_r, out_match_r, out_status_r};

  // a scan only ever runs over a non-empty list
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (used_r != '0))
    else $error("scan running on empty list");

  // the fill count never passes the capacity
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CapW)
    else $error("fill count above capacity");

  // the list length does not move during a rotation
  a_scan_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(used_r))
    else $error("length changed during scan");

  // a finished count cannot exceed the entries in use
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (cnt_r <= used_r))
    else $error("match count above length");

endmodule
